// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expression must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/mapsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mapsc_pkg
// shared widths, constants and types of the steering controller
// ----------------------------------------------------------------------------
package mapsc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int DIFF_W    = 13;
  localparam int GAIN_W    = 16;
  localparam int DUTY_W    = 10;
  localparam int AVG_W     = 12;
  localparam int GAIN_FRAC = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd999;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_KP      = 2'd0,
    REG_STANDBY_DUTY = 2'd1
  } reg_idx_t;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic vld;
    logic fan;
  } stage_tag_t;

endpackage

// ===== sv/mapsc_window.sv =====
// ----------------------------------------------------------------------------
// mapsc_window
// difference delay line with running window total, first pipeline stage
// ----------------------------------------------------------------------------
module mapsc_window #(
  parameter int WINDOW_LEN = 8,
  parameter int TOTAL_W    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mapsc_pkg::stage_tag_t                 up_tag,
  input  logic signed [mapsc_pkg::DIFF_W-1:0]   up_diff,
  output logic                                  up_stall,
  output mapsc_pkg::stage_tag_t                 dn_tag,
  output logic signed [TOTAL_W-1:0]             dn_total,
  input  logic                                  dn_stall
);

  logic                                 load;
  logic                                 take;
  logic signed [mapsc_pkg::DIFF_W-1:0]  taps [WINDOW_LEN];
  logic signed [TOTAL_W-1:0]            total;
  logic signed [TOTAL_W-1:0]            total_next;

  assign load     = !dn_tag.vld || !dn_stall;
  assign take     = up_tag.vld && load;
  assign up_stall = !load;

  // oldest tap drops out, new difference comes in
  assign total_next = total - TOTAL_W'(taps[WINDOW_LEN-1]) + TOTAL_W'(up_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      dn_tag <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        taps[i] <= '0;
      end
    end else begin
      if (take) begin
        taps[0] <= up_diff;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          taps[i] <= taps[i-1];
        end
        total <= total_next;
      end
      if (load) begin
        dn_tag <= up_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_total <= total_next;
    end
  end

endmodule

// ===== sv/mapsc_avg.sv =====
// ----------------------------------------------------------------------------
// mapsc_avg
// magnitude of window total divided by window length, two stages
// ----------------------------------------------------------------------------
module mapsc_avg #(
  parameter int WINDOW_LEN = 8,
  parameter int TOTAL_W    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mapsc_pkg::stage_tag_t             up_tag,
  input  logic signed [TOTAL_W-1:0]         up_total,
  output logic                              up_stall,
  output mapsc_pkg::stage_tag_t             dn_tag,
  output logic [mapsc_pkg::AVG_W-1:0]       dn_avg,
  input  logic                              dn_stall
);

  // |total| always fits one bit narrower than the signed total
  localparam int XW = TOTAL_W - 1;
  // floor reciprocal: the estimate is low by at most one
  localparam logic [XW:0]   RECIP = (XW+1)'((64'd1 << XW) / WINDOW_LEN);
  localparam logic [XW-1:0] DIV_N = XW'(WINDOW_LEN);

  mapsc_pkg::stage_tag_t  tag_b;
  logic [XW-1:0]          mag;
  logic [2*XW:0]          prod;
  logic [XW-1:0]          x_b;
  logic [XW-1:0]          q_b;
  logic [XW-1:0]          qn;
  logic [XW-1:0]          rem;
  logic [XW-1:0]          q_fix;
  logic                   load_b;
  logic                   load_c;

  assign load_c   = !dn_tag.vld || !dn_stall;
  assign load_b   = !tag_b.vld || load_c;
  assign up_stall = !load_b;

  assign mag  = up_total[TOTAL_W-1] ? XW'(-up_total) : XW'(up_total);
  assign prod = mag * RECIP;

  assign qn    = q_b * DIV_N;
  assign rem   = x_b - qn;
  assign q_fix = (rem >= DIV_N) ? q_b + XW'(1) : q_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_b  <= '0;
      dn_tag <= '0;
    end else begin
      if (load_b) begin
        tag_b <= up_tag;
      end
      if (load_c) begin
        dn_tag <= tag_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      x_b <= mag;
      q_b <= prod[XW +: XW];
    end
    if (load_c) begin
      dn_avg <= mapsc_pkg::AVG_W'(q_fix);
    end
  end

endmodule

// ===== sv/mapsc_duty.sv =====
// ----------------------------------------------------------------------------
// mapsc_duty
// gain multiply, clamp and fan steering into the output register
// ----------------------------------------------------------------------------
module mapsc_duty (
  input  logic                               clk,
  input  logic                               rst,
  input  mapsc_pkg::stage_tag_t              up_tag,
  input  logic [mapsc_pkg::AVG_W-1:0]        up_avg,
  output logic                               up_stall,
  input  logic [mapsc_pkg::GAIN_W-1:0]       gain_kp,
  input  logic [mapsc_pkg::DUTY_W-1:0]       standby_duty,
  output logic                               out_valid,
  output logic                               fan_select,
  output logic [mapsc_pkg::DUTY_W-1:0]       duty_pwm_channel,
  output logic [mapsc_pkg::DUTY_W-1:0]       duty_dac_channel,
  input  logic                               out_stall
);

  localparam int PROD_W   = mapsc_pkg::GAIN_W + mapsc_pkg::AVG_W;
  localparam int SCALED_W = PROD_W - mapsc_pkg::GAIN_FRAC;

  logic                              load;
  logic [PROD_W-1:0]                 prod;
  logic [SCALED_W-1:0]               scaled;
  logic [mapsc_pkg::DUTY_W-1:0]      duty;

  assign load     = !out_valid || !out_stall;
  assign up_stall = !load;

  assign prod   = gain_kp * up_avg;
  assign scaled = prod[mapsc_pkg::GAIN_FRAC +: SCALED_W];
  assign duty   = (scaled > SCALED_W'(mapsc_pkg::DUTY_MAX)) ? mapsc_pkg::DUTY_MAX
                                                           : scaled[mapsc_pkg::DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= up_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fan_select       <= up_tag.fan;
      duty_pwm_channel <= up_tag.fan ? duty : standby_duty;
      duty_dac_channel <= up_tag.fan ? standby_duty : duty;
    end
  end

endmodule

// ===== sv/moving_average_p_steering_control.sv =====
// ----------------------------------------------------------------------------
// moving_average_p_steering_control
// moving-average proportional steering controller for two fans
// ----------------------------------------------------------------------------
// Takes one left/right inductor sample pair per cycle. The duty result goes
// to the output through four register stages (window, reciprocal multiply,
// correction, gain multiply + output register); a pair with equal samples
// gives no result and leaves the window alone. The pipeline takes one pair
// per clock: every stage holds one item and moves on whenever the stage
// after it is free, so it only stops taking pairs when every stage is full
// and the output is stalled.
// The window is a WINDOW_LEN deep shift line of differences with a running
// total; the average truncates toward zero, is scaled by the Q8.8 gain,
// truncated and clamped to 999. The fan with the larger sample (left on a
// tie) gets that duty, the other gets standby_duty. Registers: index 0 is
// gain_kp (reset 256 = 1.0), index 1 is standby_duty (reset 0); other
// indexes are ignored. Write registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module moving_average_p_steering_control #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration writes
  input  logic                                   cfg_write,
  input  logic [mapsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mapsc_pkg::CFG_DATA_W-1:0]       cfg_data,
  // sample channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [mapsc_pkg::SAMPLE_W-1:0]         left_sample,
  input  logic [mapsc_pkg::SAMPLE_W-1:0]         right_sample,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   fan_select,
  output logic [mapsc_pkg::DUTY_W-1:0]           duty_pwm_channel,
  output logic [mapsc_pkg::DUTY_W-1:0]           duty_dac_channel
);

  // running total holds WINDOW_LEN differences without overflow
  localparam int TOTAL_W = mapsc_pkg::DIFF_W + $clog2(WINDOW_LEN);

  logic [mapsc_pkg::GAIN_W-1:0]           gain_kp;
  logic [mapsc_pkg::DUTY_W-1:0]           standby_duty;

  logic signed [mapsc_pkg::DIFF_W-1:0]    diff;
  mapsc_pkg::stage_tag_t                  win_in_tag;
  mapsc_pkg::stage_tag_t                  win_tag;
  logic signed [TOTAL_W-1:0]              win_total;
  logic                                   win_stall;
  mapsc_pkg::stage_tag_t                  avg_tag;
  logic [mapsc_pkg::AVG_W-1:0]            avg_val;
  logic                                   avg_stall;
  logic                                   duty_stall;
  logic [mapsc_pkg::DUTY_W-1:0]           drive_duty;
  logic [mapsc_pkg::DUTY_W-1:0]           idle_duty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_kp      <= mapsc_pkg::GAIN_RESET;
      standby_duty <= '0;
    end else if (cfg_write) begin
      unique case (mapsc_pkg::reg_idx_t'(cfg_index))
        mapsc_pkg::REG_GAIN_KP:      gain_kp      <= cfg_data;
        mapsc_pkg::REG_STANDBY_DUTY: standby_duty <= cfg_data[mapsc_pkg::DUTY_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // signed left minus right, both zero-extended
  assign diff = $signed({1'b0, left_sample}) - $signed({1'b0, right_sample});

  // only a nonzero difference enters the pipeline; equal samples are
  // still taken off the channel but vanish here
  assign win_in_tag.vld = in_valid && (diff != '0);
  assign win_in_tag.fan = (left_sample >= right_sample);

  assign in_stall = win_stall;

  mapsc_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .TOTAL_W    (TOTAL_W)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .up_tag   (win_in_tag),
    .up_diff  (diff),
    .up_stall (win_stall),
    .dn_tag   (win_tag),
    .dn_total (win_total),
    .dn_stall (avg_stall)
  );

  mapsc_avg #(
    .WINDOW_LEN (WINDOW_LEN),
    .TOTAL_W    (TOTAL_W)
  ) u_avg (
    .clk      (clk),
    .rst      (rst),
    .up_tag   (win_tag),
    .up_total (win_total),
    .up_stall (avg_stall),
    .dn_tag   (avg_tag),
    .dn_avg   (avg_val),
    .dn_stall (duty_stall)
  );

  mapsc_duty u_duty (
    .clk              (clk),
    .rst              (rst),
    .up_tag           (avg_tag),
    .up_avg           (avg_val),
    .up_stall         (duty_stall),
    .gain_kp          (gain_kp),
    .standby_duty     (standby_duty),
    .out_valid        (out_valid),
    .fan_select       (fan_select),
    .duty_pwm_channel (duty_pwm_channel),
    .duty_dac_channel (duty_dac_channel),
    .out_stall        (out_stall)
  );

  // duty on the driven channel and on the idle one
  assign drive_duty = fan_select ? duty_pwm_channel : duty_dac_channel;
  assign idle_duty  = fan_select ? duty_dac_channel : duty_pwm_channel;

  // the driven channel never exceeds the clamp
  `ASSERT_ALWAYS(a_duty_clamped, !out_valid || (drive_duty <= mapsc_pkg::DUTY_MAX))
  // input back-pressure only appears once the output register is full
  `ASSERT_ALWAYS(a_stall_needs_full_out, !in_stall || out_valid)
  // the idle channel carries the standby duty
  `ASSERT_ALWAYS(a_idle_gets_standby, !out_valid || (idle_duty == standby_duty))

endmodule
